[rtl/core/mi3_pkg.sv]
// Shared types and constants for the 3x3 fixed-point matrix inverse.
// Used by the top level and the divider stage.
`default_nettype none
package mi3_pkg;

  localparam int N_ENT  = 9;
  localparam int A_W    = 32;
  localparam int Q_W    = 33;                 // quotient bits 32..0
  localparam int P_W    = 2 * A_W;            // entry product
  localparam int ADJ_W  = P_W + 1;            // cofactor
  localparam int DET_W  = ADJ_W + A_W + 2;    // determinant, signed
  localparam int DMAG_W = DET_W;              // determinant magnitude

  // cofactor i = a[P]*a[Q] - a[R]*a[S]
  localparam int COF_P [N_ENT] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int COF_Q [N_ENT] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int COF_R [N_ENT] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int COF_S [N_ENT] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  // sideband that travels with each item through the divider
  typedef struct packed {
    logic             valid;
    logic             sing;
    logic             dneg;
    logic [N_ENT-1:0] neg;
    logic [N_ENT-1:0] big;
  } mi3_side_t;

  localparam logic [Q_W-1:0] POS_MAX = 33'h07FFFFFFF;
  localparam logic [Q_W-1:0] NEG_MAX = 33'h080000000;

endpackage
`default_nettype wire

[rtl/core/mi3_div_stage.sv]
// One restoring-division stage: decides quotient bit BIT for all nine lanes.
// Depends on mi3_pkg.
`default_nettype none
module mi3_div_stage
  import mi3_pkg::*;
#(
  parameter int RW  = 132,
  parameter int BIT = 32
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         en,
  input  mi3_side_t                   side_i,
  input  wire  [DMAG_W-1:0]           dmag_i,
  input  wire  [N_ENT-1:0][RW-1:0]    rem_i,
  input  wire  [N_ENT-1:0][Q_W-1:0]   q_i,
  output mi3_side_t                   side_o,
  output logic [DMAG_W-1:0]           dmag_o,
  output logic [N_ENT-1:0][RW-1:0]    rem_o,
  output logic [N_ENT-1:0][Q_W-1:0]   q_o
);

  logic [RW-1:0] dsh;
  logic [N_ENT-1:0][RW-1:0]  rem_nxt;
  logic [N_ENT-1:0][Q_W-1:0] q_nxt;
  mi3_side_t                 side_r;
  logic [DMAG_W-1:0]         dmag_r;
  logic [N_ENT-1:0][RW-1:0]  rem_r;
  logic [N_ENT-1:0][Q_W-1:0] q_r;

  assign dsh = {{(RW-DMAG_W){1'b0}}, dmag_i} << BIT;

  always_comb begin
    for (int i = 0; i < N_ENT; i++) begin
      rem_nxt[i] = rem_i[i];
      q_nxt[i]   = q_i[i];
      if (rem_i[i] >= dsh) begin
        rem_nxt[i]    = rem_i[i] - dsh;
        q_nxt[i][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= '0;
    end else if (en) begin
      side_r <= side_i;
    end
    if (en) begin
      dmag_r <= dmag_i;
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
    end
  end

  assign side_o = side_r;
  assign dmag_o = dmag_r;
  assign rem_o  = rem_r;
  assign q_o    = q_r;

endmodule
`default_nettype wire

[rtl/core/matrix_inverse_3x3.sv]
// Top level of the 3x3 fixed-point matrix inverse (adjugate method).
// Depends on mi3_pkg and mi3_div_stage.
//
// Takes one matrix per cycle and returns one inverse per cycle while the
// output is not stalled. Seven stages form the products, cofactors,
// determinant, operand magnitudes and range precheck, a chain of 33
// restoring-division stages follows (one quotient bit each, nine lanes
// side by side), and one stage saturates and signs the results. A stalled
// output freezes the whole pipeline; nothing is dropped or repeated. A zero
// determinant gives all-zero entries with the singular flag set.
`default_nettype none
module matrix_inverse_3x3
  import mi3_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [287:0] in_tdata,   // a00,a01,a02,a10,a11,a12,a20,a21,a22
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [287:0] out_tdata,  // r00,r01,r02,r10,r11,r12,r20,r21,r22
  output logic [1:0]   out_tuser   // singular, overflow
);

  localparam int NUM_W = ADJ_W + 2 * FRAC_BITS;
  localparam int RW    = (NUM_W > DMAG_W + Q_W) ? NUM_W : DMAG_W + Q_W;
  localparam int NDIV  = Q_W;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic signed [A_W-1:0] a_s [N_ENT];
  always_comb begin
    for (int k = 0; k < N_ENT; k++) a_s[k] = $signed(in_tdata[A_W*k +: A_W]);
  end

  logic [7:1] v_r;

  // stage 1: entry products
  logic signed [P_W-1:0] pp_r [N_ENT];
  logic signed [P_W-1:0] pn_r [N_ENT];
  logic signed [A_W-1:0] a1_r [3];
  // stage 2: cofactors
  logic signed [ADJ_W-1:0] adj_r [N_ENT];
  logic signed [A_W-1:0]   a2_r [3];
  // stage 3: determinant partial products, cofactor magnitudes
  logic signed [ADJ_W-1:0] pl_r [3];
  logic signed [ADJ_W-1:0] ph_r [3];
  logic [ADJ_W-1:0]        mag3_r [N_ENT];
  logic [N_ENT-1:0]        neg3_r;
  // stage 4: determinant terms
  logic signed [DET_W-1:0] term_r [3];
  logic [ADJ_W-1:0]        mag4_r [N_ENT];
  logic [N_ENT-1:0]        neg4_r;
  // stage 5: determinant
  logic signed [DET_W-1:0] det_r;
  logic [ADJ_W-1:0]        mag5_r [N_ENT];
  logic [N_ENT-1:0]        neg5_r;
  // stage 6: magnitudes and scaled numerators
  logic [DMAG_W-1:0]       dmag6_r;
  logic                    dneg6_r;
  logic                    sing6_r;
  logic [RW-1:0]           num6_r [N_ENT];
  logic [N_ENT-1:0]        neg6_r;
  // stage 7: range precheck
  logic [DMAG_W-1:0]        dmag7_r;
  logic                     dneg7_r;
  logic                     sing7_r;
  logic [N_ENT-1:0][RW-1:0] num7_r;
  logic [N_ENT-1:0]         neg7_r;
  logic [N_ENT-1:0]         big7_r;

  logic signed [ADJ_W-1:0] adj_nxt [N_ENT];
  logic signed [A_W:0]     lo_s [3];
  logic signed [A_W:0]     hi_s [3];
  logic [RW-1:0]           dlim;

  always_comb begin
    for (int i = 0; i < N_ENT; i++) begin
      adj_nxt[i] = {pp_r[i][P_W-1], pp_r[i]} - {pn_r[i][P_W-1], pn_r[i]};
    end
    for (int k = 0; k < 3; k++) begin
      lo_s[k] = $signed({1'b0, adj_r[3*k][A_W-1:0]});
      hi_s[k] = adj_r[3*k][ADJ_W-1:A_W];
    end
  end

  assign dlim = {{(RW-DMAG_W){1'b0}}, dmag6_r} << Q_W;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[6:1], in_tvalid};
    end
    if (en) begin
      for (int i = 0; i < N_ENT; i++) begin
        pp_r[i]   <= a_s[COF_P[i]] * a_s[COF_Q[i]];
        pn_r[i]   <= a_s[COF_R[i]] * a_s[COF_S[i]];
        adj_r[i]  <= adj_nxt[i];
        mag3_r[i] <= adj_r[i][ADJ_W-1] ? ADJ_W'(-adj_r[i]) : ADJ_W'(adj_r[i]);
        neg3_r[i] <= adj_r[i][ADJ_W-1];
        mag4_r[i] <= mag3_r[i];
        mag5_r[i] <= mag4_r[i];
        num6_r[i] <= {{(RW-ADJ_W){1'b0}}, mag5_r[i]} << (2 * FRAC_BITS);
        num7_r[i] <= num6_r[i];
        big7_r[i] <= num6_r[i] >= dlim;
      end
      for (int k = 0; k < 3; k++) begin
        a1_r[k]   <= a_s[k];
        a2_r[k]   <= a1_r[k];
        pl_r[k]   <= a2_r[k] * lo_s[k];
        ph_r[k]   <= a2_r[k] * hi_s[k];
        term_r[k] <= {{(DET_W-ADJ_W){pl_r[k][ADJ_W-1]}}, pl_r[k]}
                   + ({{(DET_W-ADJ_W){ph_r[k][ADJ_W-1]}}, ph_r[k]} <<< A_W);
      end
      neg4_r  <= neg3_r;
      neg5_r  <= neg4_r;
      neg6_r  <= neg5_r;
      neg7_r  <= neg6_r;
      det_r   <= term_r[0] + term_r[1] + term_r[2];
      dmag6_r <= det_r[DET_W-1] ? DMAG_W'(-det_r) : DMAG_W'(det_r);
      dneg6_r <= det_r[DET_W-1];
      sing6_r <= det_r == '0;
      dmag7_r <= dmag6_r;
      dneg7_r <= dneg6_r;
      sing7_r <= sing6_r;
    end
  end

  // divider chain
  mi3_side_t                 side_c [NDIV+1];
  logic [DMAG_W-1:0]         dmag_c [NDIV+1];
  logic [N_ENT-1:0][RW-1:0]  rem_c  [NDIV+1];
  logic [N_ENT-1:0][Q_W-1:0] q_c    [NDIV+1];

  always_comb begin
    side_c[0]       = '0;
    side_c[0].valid = v_r[7];
    side_c[0].sing  = sing7_r;
    side_c[0].dneg  = dneg7_r;
    side_c[0].neg   = neg7_r;
    side_c[0].big   = big7_r;
  end
  assign dmag_c[0] = dmag7_r;
  assign rem_c[0]  = num7_r;
  assign q_c[0]    = '0;

  for (genvar s = 0; s < NDIV; s++) begin : g_div
    mi3_div_stage #(.RW(RW), .BIT(NDIV - 1 - s)) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .side_i (side_c[s]),
      .dmag_i (dmag_c[s]),
      .rem_i  (rem_c[s]),
      .q_i    (q_c[s]),
      .side_o (side_c[s+1]),
      .dmag_o (dmag_c[s+1]),
      .rem_o  (rem_c[s+1]),
      .q_o    (q_c[s+1])
    );
  end

  // saturate, sign and register the result
  mi3_side_t        sf;
  logic [287:0]     data_nxt;
  logic [N_ENT-1:0] ovf;
  logic             rneg;
  logic [Q_W-1:0]   q;

  assign sf = side_c[NDIV];

  always_comb begin
    data_nxt = '0;
    ovf      = '0;
    for (int i = 0; i < N_ENT; i++) begin
      q    = q_c[NDIV][i];
      rneg = sf.neg[i] ^ sf.dneg;
      if (rneg) begin
        if (sf.big[i] || q > NEG_MAX) begin
          data_nxt[A_W*i +: A_W] = 32'h80000000;
          ovf[i] = 1'b1;
        end else begin
          data_nxt[A_W*i +: A_W] = 32'h0 - q[A_W-1:0];
        end
      end else begin
        if (sf.big[i] || q > POS_MAX) begin
          data_nxt[A_W*i +: A_W] = 32'h7FFFFFFF;
          ovf[i] = 1'b1;
        end else begin
          data_nxt[A_W*i +: A_W] = q[A_W-1:0];
        end
      end
    end
    if (sf.sing) data_nxt = '0;
  end

  logic         out_valid_r;
  logic [287:0] out_data_r;
  logic [1:0]   out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sf.valid;
    end
    if (en) begin
      out_data_r <= data_nxt;
      out_user_r <= {(|ovf) & !sf.sing, sf.sing};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire

[rtl/core/mi3_checker.sv]
// Port-level checks for matrix_inverse_3x3, attached by bind.
// Depends on the top level's port list only.
`default_nettype none
module mi3_checker (
  input wire         clk,
  input wire         rst_n,
  input wire         in_tvalid,
  input wire         in_tready,
  input wire         out_tvalid,
  input wire         out_tready,
  input wire [287:0] out_tdata,
  input wire [1:0]   out_tuser
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // singular result carries zero entries and no overflow
  a_sing: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0 && !out_tuser[1])
    else $error("singular result not cleared");

  // input side is ready exactly when the pipeline can advance
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("ready does not follow output stall");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind matrix_inverse_3x3 mi3_checker u_mi3_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
